@@ hw/rtl/sliding_window_min_max_top_assert.svh @@
// Assertion macros for the sliding window min/max block.
// Expects clk and rst_n in the scope of each use.
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SWMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SWMM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/swmm_pkg.sv @@
// Shared constants and word types for the sliding window min/max block.
// No dependencies.
package swmm_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int CFG_W      = 11;
    localparam int DATA_W     = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     restart;
    } sample_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] window_min;
        logic signed [DATA_W-1:0] window_max;
    } result_word_t;

endpackage

@@ hw/rtl/sliding_window_min_max_top.sv @@
// Sliding window min/max: the top level and its only module.
// Depends on swmm_pkg and sliding_window_min_max_top_assert.svh.
//
// Samples are stored in a 1024-entry RAM (one write port, one registered
// read port). An accepted word that does not yet fill the window gives no
// result. While the window size holds steady and neither current extreme
// is the sample that drops out, the new sample is merged into the kept
// extremes and the result passed to the output register. When an extreme
// drops out, after a restart, or after a window size change, the window is
// rescanned through the read port, one entry per cycle, before the result
// goes to the output register. After a word with a result, the next word
// waits until the output register has loaded that result. No word is taken
// while the scan runs; a result waiting at the output does not stop the
// next accept, but the following result waits for the output register, and
// the input stalls meanwhile. The window size register may only be written
// while the block is idle; zero acts as one, values above 1024 as 1024.
`include "sliding_window_min_max_top_assert.svh"

module sliding_window_min_max_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  swmm_pkg::sample_word_t  sample_word,
    output logic                    result_valid,
    input  logic                    result_stall,
    output swmm_pkg::result_word_t  result_word,
    input  logic                    cfg_wen,
    input  logic [swmm_pkg::CFG_W-1:0] cfg_wdata
);
    import swmm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_MAX - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_MAX);

    // Sample RAM
    logic signed [DATA_W-1:0] mem [WINDOW_MAX];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]        rd_pos_reg;
    logic                     rd_valid_reg;

    state_t state_reg, state_next;
    logic [CFG_W-1:0]  window_size_reg;
    logic [ADDR_W-1:0] wr_pos_reg, wr_pos_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  last_w_reg, last_w_next;
    logic              prev_ok_reg, prev_ok_next;
    logic signed [DATA_W-1:0] min_reg, min_next, max_reg, max_next;
    logic [ADDR_W-1:0] min_age_reg, min_age_next, max_age_reg, max_age_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              result_valid_reg, result_valid_next;
    result_word_t      result_word_reg;

    logic              accept;
    logic              rd_en;
    logic              out_load;
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] leave_pos;
    logic [CNT_W-1:0]  fill_base;
    logic [CNT_W-1:0]  fill_new;
    logic [CNT_W-1:0]  w_eff;
    logic              has_result;
    logic              fast_ok;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign rd_en        = (state_reg == S_SCAN) && (scan_cnt_reg != '0);
    assign out_load     = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // Clamp the configured window size
    always_comb
    begin
        if (window_size_reg == '0)
            w_eff = CNT_W'(1);
        else if (32'(window_size_reg) > 32'(WINDOW_MAX))
            w_eff = FULL_CNT;
        else
            w_eff = CNT_W'(window_size_reg);
    end

    // Slot, fill count and the slot that drops out of the window
    always_comb
    begin
        pos       = sample_word.restart ? '0 : wr_pos_reg;
        fill_base = sample_word.restart ? '0 : fill_reg;
        fill_new  = (fill_base == FULL_CNT) ? FULL_CNT : fill_base + CNT_W'(1);
        if ((CNT_W)'(pos) >= w_eff)
            leave_pos = ADDR_W'((CNT_W)'(pos) - w_eff);
        else
            leave_pos = ADDR_W'((CNT_W)'(pos) + FULL_CNT - w_eff);
        has_result = (fill_new >= w_eff);
        fast_ok    = prev_ok_reg && !sample_word.restart && (w_eff == last_w_reg)
                     && (min_age_reg != leave_pos) && (max_age_reg != leave_pos);
    end

    // Sequencer: accept, merge or rescan, then hand over the result
    always_comb
    begin
        state_next    = state_reg;
        wr_pos_next   = wr_pos_reg;
        fill_next     = fill_reg;
        last_w_next   = last_w_reg;
        prev_ok_next  = prev_ok_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        min_age_next  = min_age_reg;
        max_age_next  = max_age_reg;
        rd_addr_next  = rd_addr_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wr_pos_next  = (pos == LAST_ADDR) ? '0 : pos + ADDR_W'(1);
                    fill_next    = fill_new;
                    last_w_next  = w_eff;
                    prev_ok_next = has_result;
                    if (has_result && fast_ok)
                    begin
                        // merge the new sample; ties keep the older slot
                        if (sample_word.sample < min_reg)
                        begin
                            min_next     = sample_word.sample;
                            min_age_next = pos;
                        end
                        if (sample_word.sample > max_reg)
                        begin
                            max_next     = sample_word.sample;
                            max_age_next = pos;
                        end
                        state_next = S_DONE;
                    end
                    else if (has_result)
                    begin
                        // seed a rescan with the newest sample
                        min_next      = sample_word.sample;
                        max_next      = sample_word.sample;
                        min_age_next  = pos;
                        max_age_next  = pos;
                        rd_addr_next  = (pos == '0) ? LAST_ADDR : pos - ADDR_W'(1);
                        scan_cnt_next = w_eff - CNT_W'(1);
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // advance the read pointer toward older samples
                if (rd_en)
                begin
                    rd_addr_next  = (rd_addr_reg == '0) ? LAST_ADDR : rd_addr_reg - ADDR_W'(1);
                    scan_cnt_next = scan_cnt_reg - CNT_W'(1);
                end
                // fold in the returned sample; <= and >= move to the older slot
                if (rd_valid_reg)
                begin
                    if (rd_data_reg <= min_reg)
                    begin
                        min_next     = rd_data_reg;
                        min_age_next = rd_pos_reg;
                    end
                    if (rd_data_reg >= max_reg)
                    begin
                        max_next     = rd_data_reg;
                        max_age_next = rd_pos_reg;
                    end
                end
                if (scan_cnt_reg == '0)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the output word until taken
    assign result_valid_next = out_load || (result_valid_reg && result_stall);

    // Control and extreme registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_size_reg  <= CFG_W'(1);
            wr_pos_reg       <= '0;
            fill_reg         <= '0;
            last_w_reg       <= '0;
            prev_ok_reg      <= 1'b0;
            min_reg          <= '0;
            max_reg          <= '0;
            min_age_reg      <= '0;
            max_age_reg      <= '0;
            rd_addr_reg      <= '0;
            scan_cnt_reg     <= '0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_wen)
                window_size_reg <= cfg_wdata;
            wr_pos_reg       <= wr_pos_next;
            fill_reg         <= fill_next;
            last_w_reg       <= last_w_next;
            prev_ok_reg      <= prev_ok_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            min_age_reg      <= min_age_next;
            max_age_reg      <= max_age_next;
            rd_addr_reg      <= rd_addr_next;
            scan_cnt_reg     <= scan_cnt_next;
            rd_valid_reg     <= rd_en;
            result_valid_reg <= result_valid_next;
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_word_reg.window_min <= min_reg;
            result_word_reg.window_max <= max_reg;
        end
    end

    // Sample RAM: write on accept, registered read during a scan
    always_ff @(posedge clk)
    begin
        if (accept)
            mem[pos] <= sample_word.sample;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg];
            rd_pos_reg  <= rd_addr_reg;
        end
    end

    // Checks
    `SWMM_ASSERT_IMP(a_rd_only_in_scan, rd_valid_reg, state_reg == S_SCAN, "read data outside scan")
    `SWMM_ASSERT_IMP(a_cnt_idle_zero, state_reg == S_IDLE, scan_cnt_reg == '0, "scan count left over")
    `SWMM_ASSERT_NXT(a_result_leaves_idle, accept && has_result, state_reg != S_IDLE, "result lost")

endmodule
